@@ rtl/tccw_pkg.sv @@
// Shared types and constants for the text console cell writer.
package tccw_pkg;

    // Fixed widths of the stream fields.
    localparam int CHAR_W    = 8;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int TDATA_W   = 24;
    localparam int TUSER_W   = 1;

    // Operation codes carried on s_tuser.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Character codes with special handling.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK,
        ST_EMIT
    } tccw_state_t;

endpackage

@@ rtl/tccw_screen_ram.sv @@
// Character cell memory: one write port and one registered read port.
module tccw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [tccw_pkg::CHAR_W-1:0]  wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [tccw_pkg::CHAR_W-1:0]  rdata
);

    logic [tccw_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tccw_pkg::CHAR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/text_console_cell_writer_top.sv @@
// Text console cell writer: cursor control, scroll sequencer and result stage.
// Ordinary puts, CR, LF without scroll and NUL are handled in the idle state; a read of a cell
// passes through the READ state because of the registered memory read port.
// A scroll passes through the BLANK state: rows are addressed through a circular top-row
// pointer and only the new bottom row is blanked, one cell per cycle.
// After aresetn the block clears all COLUMNS * ROWS cells to spaces, one per cycle,
// and accepts no beat until that pass ends; the cursor resets to row 0, column 0.
module text_console_cell_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // character [7:0], read_column [14:8], read_row [19:15], zero fill above
    input  logic [tccw_pkg::TDATA_W-1:0]  s_tdata,
    // operation [0]
    input  logic [tccw_pkg::TUSER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_character [7:0], cursor_column [14:8], cursor_row [19:15], scrolled [20]
    output logic [tccw_pkg::TDATA_W-1:0]  m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    tccw_pkg::tccw_state_t state_reg, state_next;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] base_reg, base_next;

    logic [AW-1:0] sweep_addr_reg;
    logic [AW-1:0] sweep_end_reg;
    logic          sweep_first_reg;
    logic          sweep_put_reg;
    logic [tccw_pkg::CHAR_W-1:0] sweep_char_reg;
    logic          sweep_done;

    logic [tccw_pkg::CHAR_W-1:0] hold_rd_reg;
    logic [CW-1:0] hold_col_reg;
    logic [RW-1:0] hold_row_reg;
    logic          hold_scr_reg;

    logic                          m_tvalid_reg;
    logic [tccw_pkg::TDATA_W-1:0]  m_tdata_reg;

    logic                          in_op;
    logic [tccw_pkg::CHAR_W-1:0]   in_char;
    logic [6:0]                    in_rcol;
    logic [4:0]                    in_rrow;

    logic accept;
    logic is_read, is_put, is_print, is_cr, is_lf;
    logic rd_in_range, need_read;
    logic wrap, at_last, do_lf, do_scroll;
    logic [RW-1:0] wr_row;
    logic [CW-1:0] wr_col;
    logic [AW-1:0] wr_addr_idle;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] blank_start;
    logic out_free;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [tccw_pkg::CHAR_W-1:0]   mem_wdata;
    logic                          mem_re;
    logic [tccw_pkg::CHAR_W-1:0]   mem_q;

    logic                          res_valid;
    logic [tccw_pkg::CHAR_W-1:0]   res_rd;
    logic [CW-1:0]                 res_col;
    logic [RW-1:0]                 res_row;
    logic                          res_scr;

    // Logical row to physical memory row through the circular top-row pointer.
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] row);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (32'(sum) >= ROWS) begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    assign in_op   = s_tuser[0];
    assign in_char = s_tdata[7:0];
    assign in_rcol = s_tdata[14:8];
    assign in_rrow = s_tdata[19:15];

    assign s_tready = (state_reg == tccw_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Decode of the item offered in the idle state.
    always_comb begin
        is_read     = (in_op == tccw_pkg::OP_READ);
        is_put      = (in_op == tccw_pkg::OP_PUT);
        is_cr       = is_put && (in_char == tccw_pkg::CHAR_CR);
        is_lf       = is_put && (in_char == tccw_pkg::CHAR_LF);
        is_print    = is_put && (in_char != tccw_pkg::CHAR_NUL) && !is_cr && !is_lf;
        rd_in_range = (32'(in_rcol) < COLUMNS) && (32'(in_rrow) < ROWS);
        need_read   = is_read && rd_in_range;
        wrap        = (32'(col_reg) >= COLUMNS);
        at_last     = (row_reg == RW'(ROWS - 1));
        do_lf       = is_lf || (is_print && wrap);
        do_scroll   = do_lf && at_last;

        col_next = col_reg;
        if (is_cr) begin
            col_next = '0;
        end else if (is_print) begin
            col_next = wrap ? CW'(1) : col_reg + CW'(1);
        end

        row_next = (do_lf && !at_last) ? row_reg + RW'(1) : row_reg;

        base_next = base_reg;
        if (do_scroll) begin
            base_next = (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + RW'(1);
        end

        wr_row       = row_next;
        wr_col       = wrap ? '0 : col_reg;
        wr_addr_idle = AW'(phys_row(base_reg, wr_row)) * AW'(COLUMNS) + AW'(wr_col);
        rd_addr      = AW'(phys_row(base_reg, RW'(in_rrow))) * AW'(COLUMNS)
                     + AW'(in_rcol);
        // The old top row becomes the new bottom row after a scroll.
        blank_start  = AW'(base_reg) * AW'(COLUMNS);
    end

    assign sweep_done = (sweep_addr_reg == sweep_end_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                if (sweep_done) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (need_read) begin
                        state_next = tccw_pkg::ST_READ;
                    end else if (do_scroll) begin
                        state_next = tccw_pkg::ST_BLANK;
                    end else if (!out_free) begin
                        state_next = tccw_pkg::ST_EMIT;
                    end
                end
            end
            tccw_pkg::ST_READ: begin
                state_next = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_EMIT;
            end
            tccw_pkg::ST_BLANK: begin
                if (sweep_done) begin
                    state_next = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_EMIT;
                end
            end
            tccw_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default: state_next = tccw_pkg::ST_CLEAR;
        endcase
    end

    // Memory controls and the finished result for each state.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_addr_reg;
        mem_wdata = tccw_pkg::CHAR_BLANK;
        mem_re    = 1'b0;
        res_valid = 1'b0;
        res_rd    = hold_rd_reg;
        res_col   = hold_col_reg;
        res_row   = hold_row_reg;
        res_scr   = hold_scr_reg;
        unique case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            tccw_pkg::ST_IDLE: begin
                mem_we    = accept && is_print && !do_scroll;
                mem_waddr = wr_addr_idle;
                mem_wdata = in_char;
                mem_re    = accept && need_read;
                res_valid = accept && !need_read && !do_scroll;
                res_rd    = '0;
                res_col   = col_next;
                res_row   = row_next;
                res_scr   = 1'b0;
            end
            tccw_pkg::ST_READ: begin
                res_valid = 1'b1;
                res_rd    = mem_q;
            end
            tccw_pkg::ST_BLANK: begin
                mem_we = 1'b1;
                // A wrapped character lands in the first cell of the fresh row.
                if (sweep_first_reg && sweep_put_reg) begin
                    mem_wdata = sweep_char_reg;
                end
                res_valid = sweep_done;
            end
            tccw_pkg::ST_EMIT: begin
                res_valid = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tccw_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Cursor and top-row pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

    // Address sweep for the power-on clear and for blanking the bottom row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg  <= '0;
            sweep_end_reg   <= AW'(CELLS - 1);
            sweep_first_reg <= 1'b1;
            sweep_put_reg   <= 1'b0;
            sweep_char_reg  <= tccw_pkg::CHAR_BLANK;
        end else if (accept && do_scroll) begin
            sweep_addr_reg  <= blank_start;
            sweep_end_reg   <= blank_start + AW'(COLUMNS - 1);
            sweep_first_reg <= 1'b1;
            sweep_put_reg   <= is_print;
            sweep_char_reg  <= in_char;
        end else if ((state_reg == tccw_pkg::ST_CLEAR || state_reg == tccw_pkg::ST_BLANK)
                     && !sweep_done) begin
            sweep_addr_reg  <= sweep_addr_reg + AW'(1);
            sweep_first_reg <= 1'b0;
        end
    end

    // Result held while the sequencer finishes or the output stage is busy.
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_rd_reg  <= '0;
            hold_col_reg <= col_next;
            hold_row_reg <= row_next;
            hold_scr_reg <= do_scroll;
        end else if (state_reg == tccw_pkg::ST_READ) begin
            hold_rd_reg  <= mem_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_tdata_reg <= {3'b000, res_scr,
                            tccw_pkg::OUT_ROW_W'(res_row),
                            tccw_pkg::OUT_COL_W'(res_col),
                            res_rd};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tccw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(row_reg) < ROWS) && (32'(base_reg) < ROWS))
        else $error("cursor row or top-row pointer beyond the screen");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) <= COLUMNS)
        else $error("cursor column beyond the screen width");

    a_sweep_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tccw_pkg::ST_CLEAR || state_reg == tccw_pkg::ST_BLANK)
        |-> (sweep_addr_reg <= sweep_end_reg))
        else $error("cell sweep ran past its last address");

    a_scroll_blanks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && do_scroll) |=> (state_reg == tccw_pkg::ST_BLANK && hold_scr_reg))
        else $error("scroll did not start a bottom row blank");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the text console cell writer with its own screen model.
module tb_top;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic                        op;
        logic [tccw_pkg::CHAR_W-1:0] ch;
        logic [6:0]                  rcol;
        logic [4:0]                  rrow;
    } console_cmd_t;

    typedef struct packed {
        logic [tccw_pkg::CHAR_W-1:0]    rd_char;
        logic [tccw_pkg::OUT_COL_W-1:0] col;
        logic [tccw_pkg::OUT_ROW_W-1:0] row;
        logic                           scrolled;
    } console_report_t;

    typedef struct packed {
        console_cmd_t    cmd;
        logic            pinned;
        console_report_t want;
    } pending_cmd_t;

    typedef struct {
        console_cmd_t    cmd;
        int              reps;
        logic            pinned;
        console_report_t want;
    } table_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tccw_pkg::TDATA_W-1:0]  s_tdata  = '0;
    logic [tccw_pkg::TUSER_W-1:0]  s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tccw_pkg::TDATA_W-1:0]  m_tdata;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int random_sent        = 0;

    pending_cmd_t    cmds_in_flight[$];
    console_report_t expected_reports[$];
    table_row_t      directed_rows[$];

    // Screen copy and cursor as the block should hold them.
    logic [tccw_pkg::CHAR_W-1:0] screen [ROWS][COLUMNS];
    int                          cursor_col;
    int                          cursor_row;

    text_console_cell_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("text_console_cell_writer_top test failed");
        $finish;
    end

    // Moves the cursor down one row, scrolling the screen when already on the last row.
    function automatic logic advance_line();
        if (cursor_row >= ROWS - 1) begin
            for (int r = 0; r < ROWS - 1; r++)
                for (int c = 0; c < COLUMNS; c++)
                    screen[r][c] = screen[r + 1][c];
            for (int c = 0; c < COLUMNS; c++)
                screen[ROWS - 1][c] = tccw_pkg::CHAR_BLANK;
            cursor_row = ROWS - 1;
            return 1'b1;
        end
        cursor_row++;
        return 1'b0;
    endfunction

    function automatic console_report_t console_step(console_cmd_t cmd);
        console_report_t rep;
        rep = '0;
        if (cmd.op == tccw_pkg::OP_READ) begin
            if (cmd.rcol < COLUMNS && cmd.rrow < ROWS)
                rep.rd_char = screen[cmd.rrow][cmd.rcol];
        end else if (cmd.ch == tccw_pkg::CHAR_NUL) begin
            // A NUL byte leaves everything as it is.
        end else if (cmd.ch == tccw_pkg::CHAR_CR) begin
            cursor_col = 0;
        end else if (cmd.ch == tccw_pkg::CHAR_LF) begin
            rep.scrolled = advance_line();
        end else begin
            // A column resting at the width wraps before the byte is written.
            if (cursor_col >= COLUMNS) begin
                cursor_col = 0;
                rep.scrolled = advance_line();
            end
            screen[cursor_row][cursor_col] = cmd.ch;
            cursor_col++;
        end
        rep.col = cursor_col[tccw_pkg::OUT_COL_W-1:0];
        rep.row = cursor_row[tccw_pkg::OUT_ROW_W-1:0];
        return rep;
    endfunction

    function automatic void compare_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [tccw_pkg::CHAR_W-1:0] printable_char();
        logic [tccw_pkg::CHAR_W-1:0] ch;
        do
            ch = tccw_pkg::CHAR_W'($urandom_range(1, 255));
        while (ch == tccw_pkg::CHAR_CR || ch == tccw_pkg::CHAR_LF);
        return ch;
    endfunction

    function automatic console_cmd_t random_read();
        console_cmd_t cmd;
        cmd.op = tccw_pkg::OP_READ;
        cmd.ch = tccw_pkg::CHAR_W'($urandom_range(0, 255));
        // Mostly cells on the screen, now and then an address past its edge.
        if ($urandom_range(0, 7) == 0) begin
            cmd.rcol = 7'($urandom_range(0, 127));
            cmd.rrow = 5'($urandom_range(0, 31));
        end else begin
            cmd.rcol = 7'($urandom_range(0, COLUMNS - 1));
            cmd.rrow = 5'($urandom_range(0, ROWS - 1));
        end
        return cmd;
    endfunction

    function automatic console_cmd_t put_cmd(logic [tccw_pkg::CHAR_W-1:0] ch);
        console_cmd_t cmd;
        cmd.op   = tccw_pkg::OP_PUT;
        cmd.ch   = ch;
        cmd.rcol = 7'($urandom_range(0, 127));
        cmd.rrow = 5'($urandom_range(0, 31));
        return cmd;
    endfunction

    function automatic void add_row(logic op, logic [tccw_pkg::CHAR_W-1:0] ch,
                                    logic [6:0] rcol, logic [4:0] rrow, int reps,
                                    logic pinned = 1'b0,
                                    logic [tccw_pkg::CHAR_W-1:0] rd = '0,
                                    logic [tccw_pkg::OUT_COL_W-1:0] col = '0,
                                    logic [tccw_pkg::OUT_ROW_W-1:0] row = '0);
        table_row_t tr;
        tr.cmd    = '{op: op, ch: ch, rcol: rcol, rrow: rrow};
        tr.reps   = reps;
        tr.pinned = pinned;
        tr.want   = '{rd_char: rd, col: col, row: row, scrolled: 1'b0};
        directed_rows.push_back(tr);
    endfunction

    task automatic send_cmd(console_cmd_t cmd, logic pinned = 1'b0, console_report_t want = '0);
        pending_cmd_t pend;
        pend.cmd    = cmd;
        pend.pinned = pinned;
        pend.want   = want;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        cmds_in_flight.push_back(pend);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, cmd.rrow, cmd.rcol, cmd.ch};
        s_tuser  <= cmd.op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        random_sent++;
    endtask

    // One line of text with reads mixed in, closed by a random line ending, a NUL or nothing.
    task automatic send_random_line();
        int len;
        int ending;
        if ($urandom_range(0, 3) == 0)
            len = $urandom_range(COLUMNS - 4, COLUMNS + 10);
        else
            len = $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0)
                send_cmd(random_read());
            send_cmd(put_cmd(printable_char()));
        end
        ending = $urandom_range(0, 9);
        if (ending <= 4) begin
            send_cmd(put_cmd(tccw_pkg::CHAR_CR));
            send_cmd(put_cmd(tccw_pkg::CHAR_LF));
        end else if (ending <= 6) begin
            send_cmd(put_cmd(tccw_pkg::CHAR_LF));
        end else if (ending == 7) begin
            send_cmd(put_cmd(tccw_pkg::CHAR_CR));
        end else if (ending == 8) begin
            send_cmd(put_cmd(tccw_pkg::CHAR_NUL));
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    // Accepted input beats update the screen model; result beats are checked in order.
    always @(posedge aclk) begin
        pending_cmd_t    pend;
        console_report_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pend = cmds_in_flight.pop_front();
                want = console_step(pend.cmd);
                expected_reports.push_back(pend.pinned ? pend.want : want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, actual 0x%0h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("read_character", want.rd_char, m_tdata[7:0]);
                    compare_field("cursor_column", want.col, m_tdata[14:8]);
                    compare_field("cursor_row", want.row, m_tdata[19:15]);
                    compare_field("scrolled", want.scrolled, m_tdata[20]);
                end
            end
        end
    end

    initial begin
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
                screen[r][c] = tccw_pkg::CHAR_BLANK;
        cursor_col = 0;
        cursor_row = 0;

        add_row(tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 1, 1'b1, tccw_pkg::CHAR_BLANK);
        add_row(tccw_pkg::OP_READ, 8'hFF, 7'd79, 5'd24, 1, 1'b1, tccw_pkg::CHAR_BLANK);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd127, 5'd31, 1, 1'b1, 8'h00);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd80, 5'd0, 1, 1'b1, 8'h00);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd25, 1, 1'b1, 8'h00);
        add_row(tccw_pkg::OP_PUT, tccw_pkg::CHAR_NUL, 7'd127, 5'd31, 1, 1'b1);
        add_row(tccw_pkg::OP_PUT, 8'hFF, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_PUT, 8'h01, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_PUT, tccw_pkg::CHAR_CR, 7'd0, 5'd0, 1, 1'b1);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_PUT, 8'h41, 7'd0, 5'd0, COLUMNS);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd79, 5'd0, 1);
        // Line feed with the column at the width.
        add_row(tccw_pkg::OP_PUT, tccw_pkg::CHAR_LF, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_PUT, 8'h43, 7'd0, 5'd0, 1);         // wraps to the next row first
        add_row(tccw_pkg::OP_PUT, 8'h44, 7'd0, 5'd0, COLUMNS - 1);
        add_row(tccw_pkg::OP_PUT, tccw_pkg::CHAR_CR, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_PUT, tccw_pkg::CHAR_LF, 7'd0, 5'd0, ROWS - 3);
        // Scrolls from the last row.
        add_row(tccw_pkg::OP_PUT, tccw_pkg::CHAR_LF, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 1);
        add_row(tccw_pkg::OP_PUT, 8'h45, 7'd0, 5'd0, COLUMNS);
        add_row(tccw_pkg::OP_PUT, 8'h46, 7'd0, 5'd0, 1);         // wrap on the last row scrolls
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd79, 5'd23, 1);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd24, 1);
        add_row(tccw_pkg::OP_PUT, 8'h7E, 7'd127, 5'd31, 1);
        add_row(tccw_pkg::OP_READ, 8'h00, 7'd1, 5'd24, 1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            repeat (directed_rows[i].reps)
                send_cmd(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].want);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 85;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 85;
                    // Hold the sender off until the block has nothing left to report.
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (expected_reports.size() != 0 || cmds_in_flight.size() != 0)
                        @(posedge aclk);
                end
                default: begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            random_sent = 0;
            while (random_sent < RANDOM_ITEMS / 4)
                send_random_line();
        end
        s_tvalid <= 1'b0;

        while (expected_reports.size() != 0 || cmds_in_flight.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("text_console_cell_writer_top test passed");
        else
            $display("text_console_cell_writer_top test failed");
        $finish;
    end

endmodule
